// ===== rtl/opmaf_pkg.sv =====
// Package for the one-pole multimode audio filter: widths, codes and the
// command and status types shared by the controller, datapath and top level.
// No dependencies.
`default_nettype none

package opmaf_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_WIDTH    = 18;
  localparam int GUARD_BITS    = 8;
  localparam int STATE_WIDTH   = SAMPLE_WIDTH + GUARD_BITS;
  localparam int COEF_FRAC     = COEF_WIDTH - 2;
  localparam int OP_WIDTH      = STATE_WIDTH + 2;
  localparam int PROD_WIDTH    = COEF_WIDTH + 1 + OP_WIDTH;
  localparam int SUM_WIDTH     = PROD_WIDTH + 2 - COEF_FRAC;
  localparam int MODE_WIDTH    = 2;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = COEF_WIDTH;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAIN = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BAND = CFG_IDX_WIDTH'(2);

  localparam logic [SAMPLE_WIDTH-1:0] HALF_SAMPLE = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 2);

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_LP   = 2'd0,
    MODE_BP   = 2'd1,
    MODE_HP   = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STG_LP  = 2'd0,
    STG_BP1 = 2'd1,
    STG_BP2 = 2'd2,
    STG_HP  = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    CS_IDLE   = 3'd0,
    CS_OPER   = 3'd1,
    CS_MULT   = 3'd2,
    CS_ACCUM  = 3'd3,
    CS_OUTPUT = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic   cap_x;
    logic   ld_op;
    stage_t stage;
    logic   do_mul;
    logic   wr_st;
    logic   ld_out;
    logic   out_fix;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/one_pole_multimode_audio_filter_core.sv =====
// One-pole multimode audio filter (low-pass, band-pass, high-pass), top level.
// Instantiates opmaf_ctrl and opmaf_dp; depends on opmaf_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one signed Q1.15 sample per beat.
//   Output channel out_valid/out_ready carries the filtered Q1.15 sample and
//   a clip flag that is set when any state or the output saturated.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data): index 0 is
//   the mode, 1 the main Q2.16 coefficient, 2 the band-pass coefficient.
//   Write it only while no sample is in flight.
// Sequence:
//   One beat is in flight at a time. Each stage of the mode runs operand
//   setup, a multiply on the shared multiplier and a state update; band-pass
//   runs its stages BP1 then BP2. The output register is then loaded, and the
//   next beat is taken after it; reserved mode 3 goes straight to the load.
// Reset and stalls:
//   Reset clears the mode, coefficients and all filter state to zero.
//   The output register holds a finished result while the receiver stalls;
//   the next input beat is still accepted and processed, and only its final
//   write to the output register waits for the slot to free up.
`default_nettype none

module one_pole_multimode_audio_filter_core
  import opmaf_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_sample_out,
  output logic                                 out_clipped,
  input  wire logic                            cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]        cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]       cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  opmaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  opmaf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in flight");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap_x, cmd.ld_op, cmd.do_mul, cmd.wr_st, cmd.ld_out}))
    else $error("more than one datapath command in a cycle");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> out_valid)
    else $error("output load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !cmd.ld_out)
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/opmaf_ctrl.sv =====
// Controller state machine for the one-pole multimode audio filter.
// Sequences operand setup, the shared multiply and the state write per stage, then the output load.
// Depends on opmaf_pkg.
`default_nettype none

module opmaf_ctrl
  import opmaf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;
  stage_t      stage_r, stage_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      stage_r <= STG_LP;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    stage_nxt   = stage_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.stage   = stage_r;
    cmd.out_fix = (sts.mode == MODE_RSVD);
    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_x = 1'b1;
          unique case (sts.mode)
            MODE_LP: begin
              stage_nxt = STG_LP;
              state_nxt = CS_OPER;
            end
            MODE_BP: begin
              stage_nxt = STG_BP1;
              state_nxt = CS_OPER;
            end
            MODE_HP: begin
              stage_nxt = STG_HP;
              state_nxt = CS_OPER;
            end
            default: begin
              state_nxt = CS_OUTPUT;
            end
          endcase
        end
      end
      CS_OPER: begin
        cmd.ld_op = 1'b1;
        state_nxt = CS_MULT;
      end
      CS_MULT: begin
        cmd.do_mul = 1'b1;
        state_nxt  = CS_ACCUM;
      end
      CS_ACCUM: begin
        cmd.wr_st = 1'b1;
        if (stage_r == STG_BP1) begin
          stage_nxt = STG_BP2;
          state_nxt = CS_OPER;
        end else begin
          state_nxt = CS_OUTPUT;
        end
      end
      CS_OUTPUT: begin
        if (!sts.out_busy) begin
          cmd.ld_out = 1'b1;
          state_nxt  = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/opmaf_dp.sv =====
// Datapath for the one-pole multimode audio filter: configuration registers,
// filter state, one shared coefficient multiplier and the output register.
// Depends on opmaf_pkg.
`default_nettype none

module opmaf_dp
  import opmaf_pkg::*;
(
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]         cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]        cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out,
  output logic                                  out_clipped,
  input  wire dp_cmd_t                          cmd,
  output dp_sts_t                               sts
);

  localparam logic signed [SUM_WIDTH-1:0] ST_MAX =
    SUM_WIDTH'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_WIDTH-1:0] ST_MIN =
    SUM_WIDTH'(-(64'sd1 <<< (STATE_WIDTH - 1)));
  localparam logic signed [PROD_WIDTH:0] PROD_HALF =
    (PROD_WIDTH + 1)'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [STATE_WIDTH:0] Y_HALF =
    (STATE_WIDTH + 1)'(64'sd1 <<< (GUARD_BITS - 1));
  localparam logic signed [STATE_WIDTH:0] OUT_MAX =
    (STATE_WIDTH + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [STATE_WIDTH:0] OUT_MIN =
    (STATE_WIDTH + 1)'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  mode_t                        mode_r, mode_nxt;
  logic [COEF_WIDTH-1:0]        main_r, main_nxt;
  logic [COEF_WIDTH-1:0]        band_r, band_nxt;
  logic signed [STATE_WIDTH-1:0] prior_r, prior_nxt;
  logic signed [STATE_WIDTH-1:0] high_r, high_nxt;
  logic signed [STATE_WIDTH-1:0] low_r, low_nxt;
  logic signed [STATE_WIDTH-1:0] x_r, x_nxt;
  logic signed [STATE_WIDTH-1:0] y_r, y_nxt;
  logic signed [STATE_WIDTH-1:0] q_r, q_nxt;
  logic signed [OP_WIDTH-1:0]    op_r, op_nxt;
  logic [COEF_WIDTH-1:0]         coef_r, coef_nxt;
  logic signed [PROD_WIDTH-1:0]  prod_r, prod_nxt;
  logic                          clip_r, clip_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                          out_clip_r, out_clip_nxt;

  logic signed [OP_WIDTH-1:0]    x_e, p_e, h_e, l_e;
  logic signed [COEF_WIDTH:0]    coef_s;
  logic signed [PROD_WIDTH:0]    prod_rnd;
  logic signed [PROD_WIDTH:0]    prod_sh;
  logic signed [SUM_WIDTH-1:0]   res_sum;
  logic signed [STATE_WIDTH-1:0] res;
  logic                          res_sat;
  logic signed [STATE_WIDTH:0]   y_rnd;
  logic signed [STATE_WIDTH:0]   y_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_out;
  logic                          y_sat;

  always_comb begin
    x_e = OP_WIDTH'(x_r);
    p_e = OP_WIDTH'(prior_r);
    h_e = OP_WIDTH'(high_r);
    l_e = OP_WIDTH'(low_r);
    coef_s = $signed({1'b0, coef_r});

    prod_rnd = (PROD_WIDTH + 1)'(prod_r) + PROD_HALF;
    prod_sh  = prod_rnd >>> COEF_FRAC;
    res_sum  = SUM_WIDTH'(prod_sh) + SUM_WIDTH'(q_r);
    res_sat  = 1'b0;
    if (res_sum > ST_MAX) begin
      res     = STATE_WIDTH'(ST_MAX);
      res_sat = 1'b1;
    end else if (res_sum < ST_MIN) begin
      res     = STATE_WIDTH'(ST_MIN);
      res_sat = 1'b1;
    end else begin
      res = STATE_WIDTH'(res_sum);
    end

    y_rnd = (STATE_WIDTH + 1)'(y_r) + Y_HALF;
    y_sh  = y_rnd >>> GUARD_BITS;
    y_sat = 1'b0;
    if (y_sh > OUT_MAX) begin
      y_out = SAMPLE_WIDTH'(OUT_MAX);
      y_sat = 1'b1;
    end else if (y_sh < OUT_MIN) begin
      y_out = SAMPLE_WIDTH'(OUT_MIN);
      y_sat = 1'b1;
    end else begin
      y_out = SAMPLE_WIDTH'(y_sh);
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    main_nxt = main_r;
    band_nxt = band_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_nxt = mode_t'(cfg_data[MODE_WIDTH-1:0]);
        REG_MAIN: main_nxt = cfg_data[COEF_WIDTH-1:0];
        REG_BAND: band_nxt = cfg_data[COEF_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    x_nxt    = x_r;
    clip_nxt = clip_r;
    if (cmd.cap_x) begin
      x_nxt    = {in_sample_in, {GUARD_BITS{1'b0}}};
      clip_nxt = 1'b0;
    end else if (cmd.wr_st) begin
      clip_nxt = clip_r | res_sat;
    end

    op_nxt   = op_r;
    q_nxt    = q_r;
    coef_nxt = coef_r;
    if (cmd.ld_op) begin
      case (cmd.stage)
        STG_LP: begin
          op_nxt   = x_e - p_e;
          q_nxt    = prior_r;
          coef_nxt = main_r;
        end
        STG_BP1: begin
          op_nxt   = x_e - p_e - h_e;
          q_nxt    = high_r;
          coef_nxt = band_r;
        end
        STG_BP2: begin
          op_nxt   = h_e - l_e;
          q_nxt    = low_r;
          coef_nxt = main_r;
        end
        default: begin
          op_nxt   = x_e - p_e + h_e;
          q_nxt    = '0;
          coef_nxt = main_r;
        end
      endcase
    end

    prod_nxt = prod_r;
    if (cmd.do_mul) begin
      prod_nxt = coef_s * op_r;
    end

    prior_nxt = prior_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    y_nxt     = y_r;
    if (cmd.wr_st) begin
      case (cmd.stage)
        STG_LP: begin
          prior_nxt = res;
          y_nxt     = res;
        end
        STG_BP1: begin
          high_nxt = res;
        end
        STG_BP2: begin
          low_nxt   = res;
          prior_nxt = x_r;
          y_nxt     = res;
        end
        default: begin
          high_nxt  = res;
          prior_nxt = x_r;
          y_nxt     = res;
        end
      endcase
    end

    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
      if (cmd.out_fix) begin
        out_sample_nxt = HALF_SAMPLE;
        out_clip_nxt   = 1'b0;
      end else begin
        out_sample_nxt = y_out;
        out_clip_nxt   = clip_r | y_sat;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LP;
      main_r      <= '0;
      band_r      <= '0;
      prior_r     <= '0;
      high_r      <= '0;
      low_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      main_r      <= main_nxt;
      band_r      <= band_nxt;
      prior_r     <= prior_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    q_r          <= q_nxt;
    op_r         <= op_nxt;
    coef_r       <= coef_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;
  assign sts.mode       = mode_r;
  assign sts.out_busy   = out_valid_r & ~out_ready;

endmodule

`default_nettype wire
